/* rtl/sfmt_pkg.sv */
// Shared types, constants and the segment code table of the segment number formatter.
// Depends on nothing; every other file of the block imports it.
package sfmt_pkg;

  localparam int unsigned DIGIT_POSITIONS_DEF = 5;
  localparam int unsigned BIN_W = 32;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W = 4 * BCD_DIGITS;
  localparam int unsigned CNT_W = $clog2(BIN_W);
  localparam int unsigned DIG_W = $clog2(BCD_DIGITS);
  localparam int unsigned HEX_DIGITS = 5;

  localparam logic [1:0] FMT_DECIMAL = 2'd0;
  localparam logic [1:0] FMT_HUNDREDTHS = 2'd1;

  localparam logic [7:0] MINUS_CODE = 8'hF7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_ANALYSE,
    ST_EMIT
  } sfmt_state_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic analyse;
    logic emit;
  } sfmt_cmd_t;

  typedef struct packed {
    logic fmt_hex;
    logic conv_last;
    logic emit_last;
  } sfmt_stat_t;

  function automatic logic [7:0] seg_lookup(input logic [4:0] idx);
    logic [7:0] code;
    unique case (idx)
      5'd0:  code = 8'h09;
      5'd1:  code = 8'hcf;
      5'd2:  code = 8'h91;
      5'd3:  code = 8'h85;
      5'd4:  code = 8'h47;
      5'd5:  code = 8'h25;
      5'd6:  code = 8'h21;
      5'd7:  code = 8'h8f;
      5'd8:  code = 8'h01;
      5'd9:  code = 8'h05;
      5'd10: code = 8'h03;
      5'd11: code = 8'h61;
      5'd12: code = 8'h39;
      5'd13: code = 8'hc1;
      5'd14: code = 8'h31;
      5'd15: code = 8'h33;
      5'd16: code = 8'h29;
      5'd17: code = 8'h43;
      5'd18: code = 8'h7b;
      5'd19: code = 8'hc9;
      5'd20: code = 8'h79;
      5'd21: code = 8'he1;
      5'd22: code = 8'h13;
      5'd23: code = 8'hf3;
      5'd24: code = 8'h49;
      5'd25: code = 8'hf7;
      5'd26: code = 8'hfd;
      5'd27: code = 8'hff;
      default: code = 8'hff;
    endcase
    return code;
  endfunction

endpackage

/* rtl/sfmt_ctrl.sv */
// Controller state machine of the segment number formatter.
// Depends on sfmt_pkg; drives the datapath through sfmt_cmd_t and reads sfmt_stat_t.
module sfmt_ctrl import sfmt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  sfmt_stat_t stat_i,
  output sfmt_cmd_t  cmd_o
);

  sfmt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = stat_i.fmt_hex ? ST_EMIT : ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        if (stat_i.conv_last) begin
          state_d = ST_ANALYSE;
        end
      end
      ST_ANALYSE: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_CONVERT: begin
        cmd_o.shift = 1'b1;
      end
      ST_ANALYSE: begin
        cmd_o.analyse = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Work commands are mutually exclusive.
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.shift, cmd_o.analyse, cmd_o.emit}))
    else $error("More than one datapath command at once.");

  // A conversion always runs into the analysis step when its last bit is shifted.
  a_convert_to_analyse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.shift && stat_i.conv_last |=> cmd_o.analyse)
    else $error("Conversion did not proceed to analysis.");

  // Emission is entered only from an analysis or a hexadecimal load.
  a_emit_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cmd_o.emit) |-> $past(cmd_o.analyse) || $past(cmd_o.load))
    else $error("Emission started without preparation.");

endmodule

/* rtl/sfmt_datapath.sv */
// Datapath of the segment number formatter: format register, shift-and-add-3 conversion,
// digit analysis and code emission. Depends on sfmt_pkg; commanded by sfmt_ctrl.
module sfmt_datapath import sfmt_pkg::*; #(
  parameter int unsigned DIGIT_POSITIONS = DIGIT_POSITIONS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_data_i,
  input  logic signed [31:0] value_i,
  input  sfmt_cmd_t         cmd_i,
  output sfmt_stat_t        stat_o,
  output logic              result_valid_o,
  output logic [7:0]        seg_code_o,
  output logic              clear_before_o,
  output logic              is_last_o
);

  logic [1:0]       fmt_q;
  logic [BIN_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0] bcd_q, bcd_d, bcd_adj;
  logic [CNT_W-1:0] cnt_q;
  logic [DIG_W-1:0] dig_q;
  logic             neg_q, hund_q, hex_q, ovf_q, minus_q, first_q;
  logic             res_valid_q;
  logic [7:0]       seg_q;
  logic             clr_q, last_q;

  logic [BIN_W-1:0] mag;
  logic [DIG_W-1:0] n_dig, avail, used;
  logic             ovf_d;
  logic [3:0]       cur_digit;
  logic [7:0]       digit_code, code;
  logic             emit_last;

  assign mag = value_i[BIN_W-1] ? (BIN_W'(0) - BIN_W'(value_i)) : BIN_W'(value_i);

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
                                                     : bcd_q[4*i +: 4];
    end
    bcd_d = {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
    bin_d = {bin_q[BIN_W-2:0], 1'b0};
  end

  always_comb begin
    n_dig = DIG_W'(1);
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        n_dig = DIG_W'(i + 1);
      end
    end
    if (hund_q && (n_dig < DIG_W'(3))) begin
      n_dig = DIG_W'(3);
    end
    avail = DIG_W'(DIGIT_POSITIONS) - DIG_W'(neg_q);
    ovf_d = n_dig > avail;
    used  = ovf_d ? avail : n_dig;
  end

  always_comb begin
    cur_digit  = bcd_q[{dig_q, 2'b00} +: 4];
    digit_code = seg_lookup({1'b0, cur_digit});
    if ((ovf_q && (dig_q == '0)) || (hund_q && (dig_q == DIG_W'(2)))) begin
      digit_code[0] = 1'b0;
    end
    code      = minus_q ? MINUS_CODE : digit_code;
    emit_last = !minus_q && (dig_q == '0);
  end

  assign stat_o.fmt_hex   = fmt_q[1];
  assign stat_o.conv_last = cnt_q == CNT_W'(BIN_W - 1);
  assign stat_o.emit_last = emit_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= FMT_DECIMAL;
      cnt_q       <= '0;
      dig_q       <= '0;
      minus_q     <= 1'b0;
      first_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        fmt_q <= cfg_data_i;
      end
      res_valid_q <= cmd_i.emit;
      if (cmd_i.load) begin
        first_q <= 1'b1;
        cnt_q   <= '0;
        if (fmt_q[1]) begin
          minus_q <= 1'b0;
          dig_q   <= DIG_W'(HEX_DIGITS - 1);
        end else begin
          minus_q <= value_i[BIN_W-1];
        end
      end
      if (cmd_i.shift) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.analyse) begin
        dig_q <= used - DIG_W'(1);
      end
      if (cmd_i.emit) begin
        first_q <= 1'b0;
        if (minus_q) begin
          minus_q <= 1'b0;
        end else if (!emit_last) begin
          dig_q <= dig_q - DIG_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hex_q  <= fmt_q[1];
      hund_q <= (fmt_q == FMT_HUNDREDTHS);
      neg_q  <= !fmt_q[1] && value_i[BIN_W-1];
      ovf_q  <= 1'b0;
      bin_q  <= mag;
      bcd_q  <= fmt_q[1] ? {{(BCD_W-16){1'b0}}, value_i[15:0]} : '0;
    end
    if (cmd_i.shift) begin
      bcd_q <= bcd_d;
      bin_q <= bin_d;
    end
    if (cmd_i.analyse) begin
      ovf_q <= ovf_d;
    end
    if (cmd_i.emit) begin
      seg_q  <= code;
      clr_q  <= first_q && !hex_q;
      last_q <= emit_last;
    end
  end

  assign result_valid_o = res_valid_q;
  assign seg_code_o     = seg_q;
  assign clear_before_o = clr_q;
  assign is_last_o      = last_q;

endmodule

/* rtl/segment_number_formatter_unit.sv */
// Segment number formatter: converts a signed value and emits its seven-segment code run.
// Top level, built of sfmt_ctrl and sfmt_datapath; depends on sfmt_pkg.
//
// An item is taken when start is high and busy is low. In the decimal formats the value is
// converted by a shift-and-add-3 unit, one bit per cycle, then an analysis step sizes the
// run and one code per cycle follows. The hexadecimal format skips conversion and analysis.
// Each code appears for one cycle with result_valid_o high and cannot be held off; the last
// code is shown in the cycle in which busy falls again.
module segment_number_formatter_unit import sfmt_pkg::*; #(
  parameter int unsigned DIGIT_POSITIONS = DIGIT_POSITIONS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] value_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_data_i,
  output logic               result_valid_o,
  output logic [7:0]         seg_code_o,
  output logic               clear_before_o,
  output logic               is_last_o
);

  sfmt_cmd_t  cmd;
  sfmt_stat_t stat;

  assign cfg_ready_o = 1'b1;

  sfmt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  sfmt_datapath #(
    .DIGIT_POSITIONS (DIGIT_POSITIONS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .seg_code_o     (seg_code_o),
    .clear_before_o (clear_before_o),
    .is_last_o      (is_last_o)
  );

  // While codes of a run are still to come, the block stays busy.
  a_busy_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !is_last_o |-> busy)
    else $error("Block went idle in the middle of a run.");

  // The final code of a run is shown once the block has returned to idle.
  a_idle_at_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && is_last_o |-> !busy)
    else $error("Block still busy on the final code.");

  // The blanking flag is never set on two consecutive codes.
  a_clear_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_before_o && result_valid_o |=> !(clear_before_o && result_valid_o))
    else $error("Blanking flagged on two consecutive codes.");

endmodule
